### rtl/mcr_pkg.sv
// Shared constants, codes and types of the midpoint circle rasterizer.
`timescale 1ns / 1ps

package mcr_pkg;

  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned RADIUS_BITS = 11;
  localparam int unsigned PIX_BITS    = 14;
  localparam int unsigned ERR_BITS    = 14;
  // Width of the intermediate decision arithmetic.
  localparam int unsigned WIDE_BITS   = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PIX_PER_STEP = 8;
  localparam int unsigned PIDX_BITS   = $clog2(PIX_PER_STEP);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // One octant step waiting to be drawn.
  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] ox;
    logic [COORD_BITS-1:0] oy;
    logic                  done;
  } job_t;

endpackage

### rtl/mcr_if.sv
// Request channels of the midpoint circle rasterizer.
`timescale 1ns / 1ps

interface mcr_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [mcr_pkg::COORD_BITS-1:0]     center_x;
  logic [mcr_pkg::COORD_BITS-1:0]     center_y;
  logic [mcr_pkg::RADIUS_BITS-1:0]    radius;

  modport source (output valid, cmd, center_x, center_y, radius, input ready);
  modport sink   (input valid, cmd, center_x, center_y, radius, output ready);
endinterface

interface mcr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mcr_pkg::PIX_BITS-1:0] pixel_x;
  logic signed [mcr_pkg::PIX_BITS-1:0] pixel_y;
  logic                              last;
  logic                              done_res;

  modport source (output valid, pixel_x, pixel_y, last, done_res, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, done_res, output ready);
endinterface

### rtl/mcr_front.sv
// Front end: takes requests, holds the walk state and issues one job per step.
`timescale 1ns / 1ps

module mcr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mcr_in_if.sink        in_chan,
  input  logic          full_i,
  output logic          push_o,
  output mcr_pkg::job_t job_o
);

  localparam int unsigned CW = mcr_pkg::COORD_BITS;
  localparam int unsigned WW = mcr_pkg::WIDE_BITS;
  localparam int unsigned EW = mcr_pkg::ERR_BITS;

  logic [CW-1:0]          cx_q, cx_d, cy_q, cy_d, ox_q, ox_d, oy_q, oy_d;
  logic signed [EW-1:0]   err_q, err_d;
  logic                   running_q, running_d;
  logic                   accept;
  logic [CW-1:0]          x_inc, y_dec, x_new, y_new;
  logic signed [WW-1:0]   err_w, y_w, e_w, xi_w, yd_w, r_w, err_n;
  logic                   finished;

  assign in_chan.ready = !full_i;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    x_inc = ox_q + CW'(1);
    y_dec = oy_q - CW'(1);
    err_w = WW'(err_q);
    y_w   = $signed({{(WW-CW){1'b0}}, oy_q});
    xi_w  = $signed({{(WW-CW){1'b0}}, x_inc});
    yd_w  = $signed({{(WW-CW){1'b0}}, y_dec});
    r_w   = $signed({{(WW-mcr_pkg::RADIUS_BITS){1'b0}}, in_chan.radius});
    e_w   = ((err_w + y_w) <<< 1) - WW'(1);
    // Three-way move: horizontal, vertical or diagonal.
    if (err_w < 0 && e_w <= 0) begin
      x_new = x_inc;
      y_new = oy_q;
      err_n = err_w + (xi_w <<< 1) + WW'(1);
    end else if (err_w > 0 && e_w > 0) begin
      x_new = ox_q;
      y_new = y_dec;
      err_n = err_w - ((yd_w <<< 1) + WW'(1));
    end else begin
      x_new = x_inc;
      y_new = y_dec;
      err_n = err_w + ((xi_w - yd_w) <<< 1);
    end
    finished = (y_new < x_new);

    cx_d      = cx_q;
    cy_d      = cy_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    err_d     = err_q;
    running_d = running_q;
    push_o    = 1'b0;
    if (accept) begin
      if (in_chan.cmd == mcr_pkg::CMD_START) begin
        if (in_chan.radius == '0) begin
          running_d = 1'b0;
        end else begin
          cx_d      = in_chan.center_x;
          cy_d      = in_chan.center_y;
          ox_d      = '0;
          oy_d      = CW'(in_chan.radius);
          err_d     = EW'(WW'(1) - (r_w <<< 1));
          running_d = 1'b1;
        end
      end else if (running_q) begin
        push_o    = 1'b1;
        ox_d      = x_new;
        oy_d      = y_new;
        err_d     = EW'(err_n);
        running_d = !finished;
      end
    end
  end

  assign job_o = '{cx: cx_q, cy: cy_q, ox: ox_q, oy: oy_q, done: finished};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q      <= '0;
      cy_q      <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
      err_q     <= '0;
      running_q <= 1'b0;
    end else begin
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      ox_q      <= ox_d;
      oy_q      <= oy_d;
      err_q     <= err_d;
      running_q <= running_d;
    end
  end

endmodule

### rtl/mcr_queue.sv
// Short job queue between the front end and the pixel emitter.
`timescale 1ns / 1ps

module mcr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcr_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mcr_pkg::job_t job_o
);

  localparam int unsigned PW = mcr_pkg::QPTR_BITS;
  localparam int unsigned NW = mcr_pkg::QCNT_BITS;
  localparam int unsigned DEPTH = mcr_pkg::QUEUE_DEPTH;

  mcr_pkg::job_t     slot_q [DEPTH];
  logic [PW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/mcr_back.sv
// Back end: walks the eight symmetric pixels of each job into the output register.
`timescale 1ns / 1ps

module mcr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  mcr_pkg::job_t job_i,
  output logic          pop_o,
  mcr_out_if.source     out_chan
);

  localparam int unsigned PW = mcr_pkg::PIX_BITS;
  localparam int unsigned KW = mcr_pkg::PIDX_BITS;

  logic [KW-1:0]        idx_q, idx_d;
  logic                 ovalid_q, ovalid_d;
  logic signed [PW-1:0] px_q, py_q, px_n, py_n;
  logic                 last_q, done_q, last_n;
  logic                 load;
  logic [PW-1:0]        cx_w, cy_w, ax_w, ay_w;

  assign load = valid_i && (!ovalid_q || out_chan.ready);

  // Bit 2 of the index swaps the offsets, bit 1 negates the column offset,
  // bit 0 negates the row offset.
  always_comb begin
    cx_w   = PW'(job_i.cx);
    cy_w   = PW'(job_i.cy);
    ax_w   = idx_q[2] ? PW'(job_i.oy) : PW'(job_i.ox);
    ay_w   = idx_q[2] ? PW'(job_i.ox) : PW'(job_i.oy);
    px_n   = $signed(idx_q[1] ? cx_w - ax_w : cx_w + ax_w);
    py_n   = $signed(idx_q[0] ? cy_w - ay_w : cy_w + ay_w);
    last_n = (idx_q == KW'(mcr_pkg::PIX_PER_STEP - 1));
    pop_o  = load && last_n;
    idx_d  = load ? idx_q + KW'(1) : idx_q;
    if (load) begin
      ovalid_d = 1'b1;
    end else if (out_chan.ready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q   <= px_n;
      py_q   <= py_n;
      last_q <= last_n;
      done_q <= last_n && job_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_chan.valid    = ovalid_q;
  assign out_chan.pixel_x  = px_q;
  assign out_chan.pixel_y  = py_q;
  assign out_chan.last     = last_q;
  assign out_chan.done_res = done_q;

endmodule

### rtl/midpoint_circle_rasterizer.sv
// Each step request yields eight pixels, one per cycle unless the receiver
// stalls; the pixel emitter sets that rate. The step's job is queued and its
// pixels are registered out. Start requests and steps while idle are taken
// one per cycle while the queue is not full, and emit nothing. A two-entry
// job queue lets requests be taken while pixels drain. Reset is asynchronous:
// the walk goes idle, the queue empties and no pixel is offered.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcr_in_if.sink    in_chan,
  mcr_out_if.source out_chan
);

  mcr_pkg::job_t push_job, head_job;
  logic          push, full, pop, head_valid;

  mcr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_chan (in_chan),
    .full_i  (full),
    .push_o  (push),
    .job_o   (push_job)
  );

  mcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  mcr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (head_valid),
    .job_i    (head_job),
    .pop_o    (pop),
    .out_chan (out_chan)
  );

endmodule

### rtl/mcr_checker.sv
// Port-level checks of the midpoint circle rasterizer, bound to the top level.
`timescale 1ns / 1ps

module mcr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [mcr_pkg::PIX_BITS-1:0] pixel_x_i,
  input logic signed [mcr_pkg::PIX_BITS-1:0] pixel_y_i,
  input logic                          last_i,
  input logic                          done_res_i
);

  // A stalled pixel keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_x_i) && $stable(pixel_y_i)
      && $stable(last_i) && $stable(done_res_i))
    else $error("stalled pixel changed");

  // The circle ends only on the last pixel of a step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i |-> last_i)
    else $error("done without last");

  // The eight pixels of a step come out without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i)
    else $error("gap inside a step");

  // Nothing is offered while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("pixel offered in reset");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_chan.valid),
  .out_ready_i (out_chan.ready),
  .pixel_x_i   (out_chan.pixel_x),
  .pixel_y_i   (out_chan.pixel_y),
  .last_i      (out_chan.last),
  .done_res_i  (out_chan.done_res)
);

### test/tb_midpoint_circle_rasterizer.sv
// Self-checking testbench for the midpoint circle rasterizer.
`timescale 1ns / 1ps

module tb_midpoint_circle_rasterizer;

  localparam int unsigned PIX_BITS    = mcr_pkg::PIX_BITS;
  localparam int unsigned COORD_BITS  = mcr_pkg::COORD_BITS;
  localparam int unsigned RADIUS_BITS = mcr_pkg::RADIUS_BITS;

  // The longest quiet stretch of a correct run is the long receiver hold-off
  // (HOLD_CYCLES) plus a few random stalls; this leaves ample margin.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_PRINTS = 40;

  typedef struct packed {
    logic signed [PIX_BITS-1:0] px;
    logic signed [PIX_BITS-1:0] py;
    logic                       last;
    logic                       done;
  } pixel_t;

  logic clk;
  logic rst_n;

  mcr_in_if  in_chan ();
  mcr_out_if out_chan ();

  midpoint_circle_rasterizer u_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Pixels still owed by the block, oldest first.
  pixel_t pixel_q[$];
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_len;
  bit holding;

  // Shadow of the circle walk.
  logic [COORD_BITS-1:0] held_cx;
  logic [COORD_BITS-1:0] held_cy;
  int off_x;
  int off_y;
  int err_term;
  bit walking;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void push_pixel(input int px, input int py, input bit last,
                                     input bit done);
    pixel_t pix;
    pix.px   = px[PIX_BITS-1:0];
    pix.py   = py[PIX_BITS-1:0];
    pix.last = last;
    pix.done = done;
    pixel_q.push_back(pix);
  endfunction

  // Updates the shadow walk for one accepted request and queues its pixels.
  function automatic void predict_request(input logic cmd, input logic [COORD_BITS-1:0] cx,
                                          input logic [COORD_BITS-1:0] cy,
                                          input logic [RADIUS_BITS-1:0] r);
    int ccx;
    int ccy;
    int nx;
    int ny;
    int decision;
    bit finished;
    if (cmd == mcr_pkg::CMD_START) begin
      if (r == '0) begin
        walking = 1'b0;
      end else begin
        held_cx  = cx;
        held_cy  = cy;
        off_x    = 0;
        off_y    = int'(r);
        err_term = 1 - 2 * int'(r);
        walking  = 1'b1;
      end
    end else if (walking) begin
      ccx = int'(held_cx);
      ccy = int'(held_cy);
      nx = off_x;
      ny = off_y;
      decision = 2 * (err_term + ny) - 1;
      if (err_term < 0 && decision <= 0) begin
        nx++;
        err_term += 2 * nx + 1;
      end else if (err_term > 0 && decision > 0) begin
        ny--;
        err_term -= 2 * ny + 1;
      end else begin
        nx++;
        ny--;
        err_term += 2 * (nx - ny);
      end
      finished = (ny < nx);
      push_pixel(ccx + off_x, ccy + off_y, 1'b0, 1'b0);
      push_pixel(ccx + off_x, ccy - off_y, 1'b0, 1'b0);
      push_pixel(ccx - off_x, ccy + off_y, 1'b0, 1'b0);
      push_pixel(ccx - off_x, ccy - off_y, 1'b0, 1'b0);
      push_pixel(ccx + off_y, ccy + off_x, 1'b0, 1'b0);
      push_pixel(ccx + off_y, ccy - off_x, 1'b0, 1'b0);
      push_pixel(ccx - off_y, ccy + off_x, 1'b0, 1'b0);
      push_pixel(ccx - off_y, ccy - off_x, 1'b1, finished);
      off_x = nx;
      off_y = ny;
      if (finished) walking = 1'b0;
    end
  endfunction

  // Offers one request from a falling edge and returns at the edge that takes it.
  task automatic send_req(input logic cmd, input logic [COORD_BITS-1:0] cx,
                          input logic [COORD_BITS-1:0] cy,
                          input logic [RADIUS_BITS-1:0] r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.cmd      <= cmd;
    in_chan.center_x <= cx;
    in_chan.center_y <= cy;
    in_chan.radius   <= r;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_request(cmd, cx, cy, r);
  endtask

  // A step carries junk in the fields it does not use.
  task automatic send_step();
    send_req(mcr_pkg::CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
             RADIUS_BITS'($urandom));
  endtask

  task automatic test_idle_steps();
    send_idle_pct = 0;
    stall_pct = 0;
    send_step();
    send_step();
    send_req(mcr_pkg::CMD_START, 12'd100, 12'd100, '0);
    send_step();
  endtask

  // Centers at both corners with the largest radius, the second start
  // abandoning the first circle.
  task automatic test_extremes();
    send_req(mcr_pkg::CMD_START, '0, '0, '1);
    repeat (3) send_step();
    send_req(mcr_pkg::CMD_START, '1, '1, '1);
    repeat (3) send_step();
  endtask

  task automatic test_unit_circle();
    send_req(mcr_pkg::CMD_START, 12'h800, 12'h7ff, 11'd1);
    send_step();
    send_step();
    send_step();
  endtask

  task automatic test_zero_radius_abort();
    send_req(mcr_pkg::CMD_START, 12'h555, 12'haaa, 11'd5);
    send_step();
    send_req(mcr_pkg::CMD_START, 12'haaa, 12'h555, '0);
    send_step();
  endtask

  // The receiver stops for a long stretch while steps keep coming, so the
  // job queue fills and the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    send_req(mcr_pkg::CMD_START, 12'd2000, 12'd2000, 11'd300);
    hold_len = HOLD_CYCLES;
    repeat (24) send_step();
  endtask

  task automatic run_random_circles(input int n_items, input int unsigned idle,
                                    input int unsigned stall);
    int sent;
    int steps;
    int roll;
    logic [RADIUS_BITS-1:0] r;
    send_idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        roll = $urandom_range(0, 99);
        if (roll < 80) r = RADIUS_BITS'($urandom_range(1, 16));
        else if (roll < 95) r = RADIUS_BITS'($urandom_range(17, 60));
        else r = RADIUS_BITS'($urandom_range(61, 2047));
        send_req(mcr_pkg::CMD_START, COORD_BITS'($urandom), COORD_BITS'($urandom), r);
        sent++;
        // Large circles and a few small ones are cut short by the next start.
        steps = (r > 60 || $urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 4096;
        while (walking && steps > 0) begin
          send_step();
          sent++;
          steps--;
        end
        if ($urandom_range(0, 3) == 0) begin
          send_step();
          sent++;
        end
      end else begin
        r = ($urandom_range(0, 3) == 0) ? '0 : RADIUS_BITS'($urandom);
        send_req(($urandom_range(0, 1) == 0) ? mcr_pkg::CMD_START : mcr_pkg::CMD_STEP,
                 COORD_BITS'($urandom), COORD_BITS'($urandom), r);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.cmd = mcr_pkg::CMD_START;
    in_chan.center_x = '0;
    in_chan.center_y = '0;
    in_chan.radius = '0;
    mismatch_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    held_cx = '0;
    held_cy = '0;
    off_x = 0;
    off_y = 0;
    err_term = 0;
    walking = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_idle_steps();
    test_extremes();
    test_unit_circle();
    test_zero_radius_abort();
    run_random_circles(70, 0, 0);
    test_backpressure();
    run_random_circles(60, 61, 0);
    run_random_circles(60, 0, 61);
    run_random_circles(60, 28, 28);

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver side: random stalls, overridden by the long hold-off.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= !holding && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Counts out the long hold-off on rising edges so the receiver sees a
  // settled flag at the falling edge.
  initial begin
    holding = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        holding = 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        holding = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b done=%0b",
                                  out_chan.pixel_x, out_chan.pixel_y, out_chan.last,
                                  out_chan.done_res));
      end else begin
        want = pixel_q.pop_front();
        if (out_chan.pixel_x !== want.px || out_chan.pixel_y !== want.py ||
            out_chan.last !== want.last || out_chan.done_res !== want.done) begin
          report_mismatch($sformatf("got (%0d,%0d) last=%0b done=%0b, want (%0d,%0d) %0b %0b",
                                    out_chan.pixel_x, out_chan.pixel_y, out_chan.last,
                                    out_chan.done_res, want.px, want.py, want.last,
                                    want.done));
        end
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    int unsigned quiet_cycles;
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

### midpoint_circle_rasterizer.f
rtl/mcr_pkg.sv
rtl/mcr_if.sv
rtl/mcr_front.sv
rtl/mcr_queue.sv
rtl/mcr_back.sv
rtl/midpoint_circle_rasterizer.sv
rtl/mcr_checker.sv
test/tb_midpoint_circle_rasterizer.sv
